// ===== hw/rtl/tsf_pkg.sv =====
// types, codes and constants shared by the tcp source rule packet filter
package tsf_pkg;

    localparam int RULE_SLOTS_DEF = 16;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VER_4       = 4'd4;
    localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;

    localparam logic [2:0] OP_PACKET = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_DEL    = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_START  = 3'd4;

    localparam logic [3:0] STAT_NOT_TCP   = 4'd0;
    localparam logic [3:0] STAT_NO_MATCH  = 4'd1;
    localparam logic [3:0] STAT_MATCH     = 4'd2;
    localparam logic [3:0] STAT_STOPPED   = 4'd3;
    localparam logic [3:0] STAT_ADDED     = 4'd4;
    localparam logic [3:0] STAT_FULL      = 4'd5;
    localparam logic [3:0] STAT_DELETED   = 4'd6;
    localparam logic [3:0] STAT_NOT_FOUND = 4'd7;
    localparam logic [3:0] STAT_SWITCH    = 4'd8;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] ether_type;
        logic [3:0]  ip_version;
        logic [7:0]  ip_protocol;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } item_t;

    typedef struct packed {
        logic        drop;
        logic [3:0]  status;
        logic [31:0] tcp_count;
    } result_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_ADD    = 2'd2,
        CMD_DEL    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic        vld;
        cmd_t        cmd;
        logic        flag;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } word_t;

endpackage

// ===== hw/rtl/tsf_cell.sv =====
// one rule slot of the filter row, passes the word on to its neighbor each cycle
module tsf_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  tsf_pkg::word_t word_in,
    output tsf_pkg::word_t word_out
);
    import tsf_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] ip_reg;
    logic [15:0] sport_reg;
    logic [15:0] tport_reg;
    logic        vld_reg;
    word_t       word_reg;
    word_t       word_next;
    logic        src_eq;
    logic        hit_rule;
    logic        same_rule;
    logic        claim;

    always_comb
    begin
        src_eq    = (ip_reg == word_in.src_ip) && (sport_reg == word_in.src_port);
        hit_rule  = valid_reg && (src_eq || (tport_reg == word_in.dst_port));
        same_rule = valid_reg && src_eq && (tport_reg == word_in.dst_port);
        claim     = word_in.vld && (word_in.cmd == CMD_ADD) && !word_in.flag && !valid_reg;
        valid_next = valid_reg;
        word_next  = word_in;
        if (word_in.vld)
        begin
            case (word_in.cmd)
                CMD_LOOKUP:
                begin
                    if (hit_rule)
                    begin
                        word_next.flag = 1'b1;
                    end
                end
                CMD_ADD:
                begin
                    if (claim)
                    begin
                        valid_next     = 1'b1;
                        word_next.flag = 1'b1;
                    end
                end
                CMD_DEL:
                begin
                    if (same_rule)
                    begin
                        valid_next     = 1'b0;
                        word_next.flag = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            vld_reg   <= word_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (claim)
        begin
            ip_reg    <= word_in.src_ip;
            sport_reg <= word_in.src_port;
            tport_reg <= word_in.dst_port;
        end
    end

    always_comb
    begin
        word_out     = word_reg;
        word_out.vld = vld_reg;
    end

endmodule

// ===== hw/rtl/tcp_source_rule_packet_filter.sv =====
// A firewall rule table built as a row of RULE_SLOTS cells, one rule per cell. Each
// accepted word (packet header or add, delete, stop, start command) walks the row one
// cell per cycle, collecting the match, free-slot and delete outcome on the way. The
// result is registered, or parked, as the word leaves the last cell. No new word is accepted
// while a word is in the row or a finished result is parked, so the row holds a single word
// at a time and the walk through the cell row sets the pace. A finished result waits
// in its own register, so a stalled result side does not hold back the next word; if
// that word finishes while the result is still stalled, it waits in a second register
// and the input stays stalled until the result side takes the first one.
// Rule valid bits clear at reset; there is no clearing pass.
module tcp_source_rule_packet_filter #(
    parameter int RULE_SLOTS = tsf_pkg::RULE_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pkt_valid,
    output logic             pkt_stall,
    input  tsf_pkg::item_t   pkt,
    output logic             res_valid,
    input  logic             res_stall,
    output tsf_pkg::result_t res
);
    import tsf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic        filter_en_reg;
    logic        filter_en_next;
    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic        ctx_drop_reg;
    logic        ctx_drop_next;
    logic [3:0]  ctx_status_reg;
    logic [3:0]  ctx_status_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    result_t     res_reg;
    result_t     res_next;
    result_t     pend_reg;
    result_t     pend_next;
    result_t     done_res;
    logic        accept;
    logic        is_tcp;
    logic        out_free;
    word_t       head_word;
    word_t       chain_w [RULE_SLOTS+1];
    word_t       tail_word;

    assign accept   = pkt_valid && !pkt_stall;
    assign out_free = !res_valid_reg || !res_stall;
    assign is_tcp   = (pkt.ether_type == ETHERTYPE_IPV4) && (pkt.ip_version == IP_VER_4)
                      && (pkt.ip_protocol == IP_PROTO_TCP);

    always_comb
    begin
        filter_en_next  = filter_en_reg;
        count_next      = count_reg;
        ctx_drop_next   = ctx_drop_reg;
        ctx_status_next = ctx_status_reg;
        head_word.vld      = accept;
        head_word.cmd      = CMD_NONE;
        head_word.flag     = 1'b0;
        head_word.src_ip   = pkt.src_ip;
        head_word.src_port = pkt.src_port;
        head_word.dst_port = pkt.dst_port;
        if (accept)
        begin
            ctx_drop_next   = 1'b0;
            ctx_status_next = STAT_NOT_TCP;
            case (pkt.op)
                OP_PACKET:
                begin
                    if (is_tcp)
                    begin
                        count_next = count_reg + 32'd1;
                        if (filter_en_reg)
                        begin
                            head_word.cmd = CMD_LOOKUP;
                        end
                        else
                        begin
                            ctx_drop_next   = 1'b1;
                            ctx_status_next = STAT_STOPPED;
                        end
                    end
                end
                OP_ADD:
                begin
                    head_word.cmd = CMD_ADD;
                end
                OP_DEL:
                begin
                    head_word.cmd = CMD_DEL;
                end
                OP_STOP:
                begin
                    filter_en_next  = 1'b0;
                    ctx_status_next = STAT_SWITCH;
                end
                OP_START:
                begin
                    filter_en_next  = 1'b1;
                    ctx_status_next = STAT_SWITCH;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign chain_w[0] = head_word;

    for (genvar k = 0; k < RULE_SLOTS; k++)
    begin : g_cell
        tsf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .word_in  (chain_w[k]),
            .word_out (chain_w[k+1])
        );
    end

    assign tail_word = chain_w[RULE_SLOTS];

    always_comb
    begin
        done_res.tcp_count = count_reg;
        done_res.drop      = 1'b0;
        case (tail_word.cmd)
            CMD_LOOKUP:
            begin
                done_res.drop   = tail_word.flag;
                done_res.status = tail_word.flag ? STAT_MATCH : STAT_NO_MATCH;
            end
            CMD_ADD:
            begin
                done_res.status = tail_word.flag ? STAT_ADDED : STAT_FULL;
            end
            CMD_DEL:
            begin
                done_res.status = tail_word.flag ? STAT_DELETED : STAT_NOT_FOUND;
            end
            default:
            begin
                done_res.drop   = ctx_drop_reg;
                done_res.status = ctx_status_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        pend_next      = pend_reg;
        res_valid_next = res_valid_reg && res_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (tail_word.vld)
                begin
                    if (out_free)
                    begin
                        res_next       = done_res;
                        res_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        pend_next  = done_res;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filter_en_reg <= 1'b1;
            count_reg     <= 32'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filter_en_reg <= filter_en_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_drop_reg   <= ctx_drop_next;
        ctx_status_reg <= ctx_status_next;
        res_reg        <= res_next;
        pend_reg       <= pend_next;
    end

    assign pkt_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/tsf_checker.sv =====
// port-level checks for the tcp source rule packet filter, bound to the top level
module tsf_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             pkt_valid,
    input logic             pkt_stall,
    input tsf_pkg::item_t   pkt,
    input logic             res_valid,
    input logic             res_stall,
    input tsf_pkg::result_t res
);
    import tsf_pkg::*;

    // one word in the row at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && !pkt_stall |=> pkt_stall)
        else $error("input taken while a word is in flight");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    a_cmd_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status == STAT_ADDED || res.status == STAT_FULL
            || res.status == STAT_DELETED || res.status == STAT_NOT_FOUND
            || res.status == STAT_SWITCH || res.status == STAT_NOT_TCP
            || res.status == STAT_NO_MATCH) |-> !res.drop)
        else $error("drop set on a non-dropping status");

    a_drop_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.drop |-> (res.status == STAT_MATCH || res.status == STAT_STOPPED))
        else $error("drop with wrong status");

endmodule

bind tcp_source_rule_packet_filter tsf_checker u_tsf_checker (.*);
